[hw/rtl/wbps_pkg.sv]
// Package for the wildcard byte pattern scan block.
// Constants, register indexes, controller states and control structs.
// No dependencies.
`default_nettype none

package wbps_pkg;

  localparam int unsigned MaxPatternDefault = 256;
  localparam int unsigned StoreDepth        = 256;  // pattern store entries
  localparam int unsigned WinDepth          = 256;  // circular window buffer
  localparam int unsigned StoreAw           = $clog2(StoreDepth);
  localparam int unsigned WinAw             = $clog2(WinDepth);
  localparam logic [7:0]  Wildcard          = 8'hFF;
  localparam logic [31:0] CountMax          = 32'hFFFF_FFFF;

  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_LENGTH = 8'd0,
    REG_REGION_BASE    = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_CHECK,
    ST_EMIT_HIT,
    ST_EMIT_MISS
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // input request taken this cycle
    logic step;     // advance compare pointers
    logic emit;     // load output register
    logic hit;      // with emit: match found
  } scan_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan;     // last accepted request was a live region byte
    logic cand;     // window must be compared
    logic last;     // last accepted byte closes the region
    logic byte_ok;  // current pattern byte matches its window byte
    logic pat_end;  // current compare position is the final pattern byte
    logic out_free; // output register can take a result this cycle
  } scan_sts_t;

endpackage

`default_nettype wire

[hw/rtl/wbps_ctrl.sv]
// Controller FSM for the wildcard byte pattern scan block.
// Sequences window compares and result emission; uses wbps_pkg.
`default_nettype none

module wbps_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire wbps_pkg::scan_sts_t sts_i,
  output wbps_pkg::scan_cmd_t   cmd_o
);

  wbps_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wbps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      wbps_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = wbps_pkg::ST_EVAL;
      end
      wbps_pkg::ST_EVAL: begin
        if (!sts_i.scan)      state_d = wbps_pkg::ST_IDLE;
        else if (sts_i.cand)  state_d = wbps_pkg::ST_READ;
        else if (sts_i.last)  state_d = wbps_pkg::ST_EMIT_MISS;
        else                  state_d = wbps_pkg::ST_IDLE;
      end
      wbps_pkg::ST_READ: begin
        // memory read data lands next cycle
        state_d = wbps_pkg::ST_CHECK;
      end
      wbps_pkg::ST_CHECK: begin
        if (!sts_i.byte_ok) begin
          state_d = sts_i.last ? wbps_pkg::ST_EMIT_MISS : wbps_pkg::ST_IDLE;
        end else if (sts_i.pat_end) begin
          state_d = wbps_pkg::ST_EMIT_HIT;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = wbps_pkg::ST_READ;
        end
      end
      wbps_pkg::ST_EMIT_HIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.hit  = 1'b1;
          state_d    = wbps_pkg::ST_IDLE;
        end
      end
      wbps_pkg::ST_EMIT_MISS: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = wbps_pkg::ST_IDLE;
        end
      end
      default: state_d = wbps_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/wbps_dp.sv]
// Datapath for the wildcard byte pattern scan block: pattern store, window
// buffer, counters, config registers and output register. Uses wbps_pkg.
`default_nettype none

module wbps_dp #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MaxPatternDefault
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // config write
  input  wire                         cfg_valid_i,
  input  wire [wbps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [63:0]                  cfg_data_i,
  // request fields
  input  wire                         mode_i,
  input  wire [7:0]                   pattern_index_i,
  input  wire [7:0]                   data_byte_i,
  input  wire                         first_byte_i,
  input  wire                         last_byte_i,
  // result
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        found_o,
  output logic [63:0]                 match_address_o,
  output logic [31:0]                 match_offset_o,
  // control
  input  wire wbps_pkg::scan_cmd_t    cmd_i,
  output wbps_pkg::scan_sts_t         sts_o
);

  localparam int unsigned SAw = wbps_pkg::StoreAw;
  localparam int unsigned WAw = wbps_pkg::WinAw;

  logic [7:0] pat_mem [wbps_pkg::StoreDepth];
  logic [7:0] win_mem [wbps_pkg::WinDepth];

  logic [7:0]     pat_rd_q, win_rd_q;
  logic [SAw-1:0] pidx_q, pidx_d;
  logic [WAw-1:0] raddr_q, raddr_d;
  logic [WAw-1:0] wptr_q, wptr_d;
  logic [31:0]    seen_q, seen_d;
  logic           done_q, done_d;
  logic [7:0]     len_q;
  logic [63:0]    base_q;
  logic           scan_q, cand_q, last_q;
  logic           scan_d, cand_d;
  logic           out_valid_q;
  logic           found_q;
  logic [63:0]    addr_q;
  logic [31:0]    off_q;

  logic        done_eff, counted, pat_wr, win_wr, len_ok;
  logic [31:0] seen_base;
  logic [31:0] off_hit;

  assign done_eff  = first_byte_i ? 1'b0 : done_q;
  assign seen_base = first_byte_i ? 32'd0 : seen_q;
  assign counted   = (seen_base != wbps_pkg::CountMax);
  assign len_ok    = (len_q != 8'd0) && ({24'd0, len_q} < 32'(MAX_PATTERN));
  assign pat_wr    = cmd_i.accept && !mode_i &&
                     ({24'd0, pattern_index_i} < 32'(MAX_PATTERN));
  assign win_wr    = cmd_i.accept && mode_i && !done_eff;
  assign off_hit   = seen_q - {24'd0, len_q};

  always_comb begin
    seen_d  = seen_q;
    done_d  = done_q;
    wptr_d  = wptr_q;
    pidx_d  = pidx_q;
    raddr_d = raddr_q;
    scan_d  = scan_q;
    cand_d  = cand_q;
    if (cmd_i.accept) begin
      scan_d = mode_i && !done_eff;
      cand_d = 1'b0;
      if (mode_i) begin
        done_d = done_eff;
        seen_d = seen_base;
        if (!done_eff) begin
          wptr_d = wptr_q + WAw'(1);
          if (counted) seen_d = seen_base + 32'd1;
          cand_d = counted && (base_q != 64'd0) && len_ok &&
                   ((seen_base + 32'd1) >= {24'd0, len_q});
          // oldest window byte of the candidate match
          pidx_d  = '0;
          raddr_d = wptr_q + WAw'(1) - WAw'(len_q);
        end
      end
    end else if (cmd_i.step) begin
      pidx_d  = pidx_q + SAw'(1);
      raddr_d = raddr_q + WAw'(1);
    end
    if (cmd_i.emit) done_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      done_q      <= 1'b0;
      wptr_q      <= '0;
      pidx_q      <= '0;
      raddr_q     <= '0;
      scan_q      <= 1'b0;
      cand_q      <= 1'b0;
      last_q      <= 1'b0;
      len_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      done_q  <= done_d;
      wptr_q  <= wptr_d;
      pidx_q  <= pidx_d;
      raddr_q <= raddr_d;
      scan_q  <= scan_d;
      cand_q  <= cand_d;
      if (cmd_i.accept) last_q <= last_byte_i;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wbps_pkg::REG_PATTERN_LENGTH: len_q  <= cfg_data_i[7:0];
          wbps_pkg::REG_REGION_BASE:    base_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.emit)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // memories and result payload
  always_ff @(posedge clk_i) begin
    if (pat_wr) pat_mem[pattern_index_i[SAw-1:0]] <= data_byte_i;
    if (win_wr) win_mem[wptr_q] <= data_byte_i;
    pat_rd_q <= pat_mem[pidx_q];
    win_rd_q <= win_mem[raddr_q];
    if (cmd_i.emit) begin
      found_q <= cmd_i.hit;
      off_q   <= cmd_i.hit ? off_hit : 32'd0;
      addr_q  <= cmd_i.hit ? (base_q + {32'd0, off_hit}) : 64'd0;
    end
  end

  assign sts_o.scan     = scan_q;
  assign sts_o.cand     = cand_q;
  assign sts_o.last     = last_q;
  assign sts_o.byte_ok  = (pat_rd_q == wbps_pkg::Wildcard) || (pat_rd_q == win_rd_q);
  assign sts_o.pat_end  = (pidx_q == SAw'(len_q - 8'd1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign match_address_o = addr_q;
  assign match_offset_o  = off_q;

endmodule

`default_nettype wire

[hw/rtl/wildcard_byte_pattern_scan.sv]
// Top level of the wildcard byte pattern scan block.
// Instantiates wbps_ctrl and wbps_dp; uses wbps_pkg.
`default_nettype none

//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/tready       | tdata, tuser=mode, tlast
//  m_axis    | out       | m_axis_tvalid/tready       | tdata, tuser=found
//  cfg       | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// A pattern load request passes only through the idle and evaluate states, as does
// a region byte with no compare. A compared region byte then reads pattern store
// and window buffer once per pattern byte, each read followed by its check, up to
// and including the first mismatch (all pattern_length bytes on a match). A result
// adds an emit state to load the output register, held while the register stays
// full under a stalled m_axis. Reset clears control and config, no memory sweep.
// Config writes are always taken (cfg_ready_o is tied high). A new request is taken only in idle.

module wildcard_byte_pattern_scan #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::MaxPatternDefault
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // request stream
  input  wire                         s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire [23:0]                  s_axis_tdata,  // [7:0] pattern_index, [15:8] data_byte,
                                                     // [16] first_byte, [23:17] zero
  input  wire                         s_axis_tuser,  // [0] mode
  input  wire                         s_axis_tlast,  // last_byte
  // result stream
  output logic                        m_axis_tvalid,
  input  wire                         m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // [63:0] match_address,
                                                     // [95:64] match_offset
  output logic                        m_axis_tuser,  // [0] found
  // config write
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [wbps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [63:0]                  cfg_data_i
);

  wbps_pkg::scan_cmd_t cmd;
  wbps_pkg::scan_sts_t sts;
  logic [63:0]         match_address;
  logic [31:0]         match_offset;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {match_offset, match_address};

  wbps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbps_dp #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mode_i          (s_axis_tuser),
    .pattern_index_i (s_axis_tdata[7:0]),
    .data_byte_i     (s_axis_tdata[15:8]),
    .first_byte_i    (s_axis_tdata[16]),
    .last_byte_i     (s_axis_tlast),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .found_o         (m_axis_tuser),
    .match_address_o (match_address),
    .match_offset_o  (match_offset),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for wildcard_byte_pattern_scan: directed table, then random phases.
// Holds its own predictor of the scan; depends on wbps_pkg and the block's RTL only.

module tb_top;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SCAN = 1'b1;
  localparam int unsigned SmallPhaseItems = 200;  // random items before the long-pattern phase
  localparam int unsigned WinKeep = 255;          // region bytes the match window can span

  typedef struct packed {
    logic       mode;
    logic [7:0] idx;
    logic [7:0] data;
    logic       first_byte;
    logic       last_byte;
  } scan_req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
    logic [31:0] off;
  } scan_res_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TYPED} chk_e;
  typedef enum logic {ROW_REQ, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e          kind;
    wbps_pkg::cfg_reg_e reg_idx;
    logic [63:0]        value;
    scan_req_t          rq;
    chk_e               chk;
    scan_res_t          want;
  } dir_row_t;

  localparam scan_res_t NotFound = '0;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [23:0]        s_axis_tdata;
  logic               s_axis_tuser;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [95:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  wbps_pkg::cfg_reg_e cfg_index;
  logic [63:0]        cfg_data;

  wildcard_byte_pattern_scan u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the pattern store, the recent region bytes
  // (newest first), the byte count of the current region and the done flag.
  // ---------------------------------------------------------------------------
  logic [7:0]  pat_mem [256];
  bit          pat_written [256];  // entries loaded so far; unloaded ones must never be compared
  logic [7:0]  hist_q [$];
  logic [31:0] seen_cnt;
  bit          region_closed;
  int unsigned cur_len;
  logic [63:0] cur_base;

  scan_res_t   res_q [$];          // results still owed by the block, oldest first

  int unsigned n_err, n_req, n_loads, n_hits, n_misses, n_settings;
  bit          tx_calm, rx_calm;   // stretches with no idling on either side
  int unsigned rx_hold;
  dir_row_t    dir_rows [$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Whole pattern window against the newest region bytes; 0xFF matches anything.
  function automatic bit window_hit();
    logic [7:0] p;
    for (int unsigned j = 0; j < cur_len; j++) begin
      p = pat_mem[j];
      if (p != wbps_pkg::Wildcard && p != hist_q[cur_len - 1 - j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advances the predicted state by one accepted request. Returns 1 when the
  // request produces a result, which is then in res.
  function automatic bit scan_predict(input scan_req_t rq, output scan_res_t res);
    bit counted;
    res = NotFound;
    if (rq.mode == MODE_LOAD) begin
      // loads only touch the store, never the search
      pat_mem[rq.idx]     = rq.data;
      pat_written[rq.idx] = 1'b1;
      return 1'b0;
    end
    if (rq.first_byte) begin
      seen_cnt      = '0;
      region_closed = 1'b0;
    end
    if (region_closed) return 1'b0;  // bytes after the result are dropped
    hist_q.push_front(rq.data);
    void'(hist_q.pop_back());
    counted = (seen_cnt != wbps_pkg::CountMax);  // a full counter puts bytes outside the region
    if (counted) seen_cnt++;
    if (counted && cur_base != '0 && cur_len != 0 && seen_cnt >= cur_len &&
        window_hit()) begin
      region_closed = 1'b1;
      res.found     = 1'b1;
      res.off       = seen_cnt - cur_len;
      res.addr      = cur_base + 64'(res.off);  // wraps modulo 2^64
      return 1'b1;
    end
    if (rq.last_byte) begin
      region_closed = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_pat_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return wbps_pkg::Wildcard;
    if (r < 7) return 8'($urandom_range(0, 3));  // narrow alphabet gives near misses
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 8) return $urandom_range(1, 4);
    return $urandom_range(5, 24);
  endfunction

  function automatic logic [63:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));  // near wrap
    if (r == 2) return 64'd1;
    return {$urandom, $urandom};
  endfunction

  function automatic scan_req_t mk_req(input logic mode, input logic [7:0] idx,
                                       input logic [7:0] data, input logic fb, input logic lb);
    scan_req_t rq;
    rq.mode       = mode;
    rq.idx        = idx;
    rq.data       = data;
    rq.first_byte = fb;
    rq.last_byte  = lb;
    return rq;
  endfunction

  function automatic dir_row_t scan_row(input logic [7:0] data, input logic fb, input logic lb,
                                        input chk_e chk, input scan_res_t want = NotFound);
    dir_row_t row;
    row.kind    = ROW_REQ;
    row.reg_idx = wbps_pkg::REG_PATTERN_LENGTH;
    row.value   = '0;
    row.rq      = mk_req(MODE_SCAN, data ^ 8'h5A, data, fb, lb);
    row.chk     = chk;
    row.want    = want;
    return row;
  endfunction

  function automatic dir_row_t load_row(input logic [7:0] idx, input logic [7:0] data);
    dir_row_t row;
    row         = scan_row(data, 1'b1, 1'b0, CHK_NONE);
    row.rq      = mk_req(MODE_LOAD, idx, data, 1'b1, 1'b0);
    return row;
  endfunction

  function automatic dir_row_t reg_row(input wbps_pkg::cfg_reg_e ri, input logic [63:0] value);
    dir_row_t row;
    row         = scan_row(8'h00, 1'b0, 1'b0, CHK_NONE);
    row.kind    = ROW_REG;
    row.reg_idx = ri;
    row.value   = value;
    return row;
  endfunction

  function automatic scan_res_t hit(input logic [63:0] addr, input logic [31:0] off);
    scan_res_t res;
    res.found = 1'b1;
    res.addr  = addr;
    res.off   = off;
    return res;
  endfunction

  // One request on s_axis. Entered and left at a falling edge; tvalid stays
  // high on return so a back-to-back request needs no second assignment.
  task automatic send_req(input scan_req_t rq, input chk_e chk = CHK_MODEL,
                          input scan_res_t want = NotFound);
    int unsigned gap;
    scan_res_t   pred;
    bit          has_res;
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {7'b0, rq.first_byte, rq.data, rq.idx};
    s_axis_tuser  <= rq.mode;
    s_axis_tlast  <= rq.last_byte;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    has_res = scan_predict(rq, pred);
    case (chk)
      CHK_MODEL: if (has_res) res_q.push_back(pred);
      CHK_TYPED: res_q.push_back(want);
      default: ;
    endcase
    n_req++;
    if (rq.mode == MODE_LOAD) n_loads++;
    @(negedge clk_i);
  endtask

  // Holds the sender until every owed result has come out.
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (res_q.size() != 0) @(negedge clk_i);
  endtask

  // Register write, only with the block idle: all results out, and long enough
  // for a region byte still in its compare loop to finish.
  task automatic write_reg(input wbps_pkg::cfg_reg_e ri, input logic [63:0] value);
    drain_pause();
    repeat (2 * cur_len + 16) @(negedge clk_i);
    cfg_index <= ri;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    if (ri == wbps_pkg::REG_PATTERN_LENGTH) cur_len = 32'(value[7:0]);
    else cur_base = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // One setting of both registers followed by a handful of regions. Pattern
  // entries the new length reaches are loaded first, so no compare ever reads
  // an unloaded entry.
  task automatic run_phase(input int unsigned plen, input logic [63:0] base,
                           input int unsigned n_regions, input int unsigned rlen_min,
                           input int unsigned rlen_extra);
    logic [63:0] len_word;
    logic [7:0]  region [$];
    int unsigned rlen, at;
    bit          narrow, fb, lb;
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < plen; i++)
      if (!pat_written[i])
        send_req(mk_req(MODE_LOAD, 8'(i), pick_pat_byte(), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1))));
    if (plen != 0)
      repeat ($urandom_range(0, 3))
        send_req(mk_req(MODE_LOAD, 8'($urandom_range(0, plen - 1)), pick_pat_byte(),
                        1'b0, 1'b0));
    // upper bits of the length word are junk the block must drop
    len_word      = {$urandom, $urandom};
    len_word[7:0] = plen[7:0];
    write_reg(wbps_pkg::REG_PATTERN_LENGTH, len_word);
    write_reg(wbps_pkg::REG_REGION_BASE, base);
    n_settings++;
    repeat (n_regions) begin
      rlen   = $urandom_range(rlen_min, plen + rlen_extra);
      narrow = 1'($urandom_range(0, 1));
      region.delete();
      for (int unsigned k = 0; k < rlen; k++)
        region.push_back(narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255)));
      // plant a copy of the pattern, wildcard positions keep their random byte
      if (plen != 0 && rlen >= plen && (plen > 24 || $urandom_range(0, 9) < 6)) begin
        at = $urandom_range(0, rlen - plen);
        for (int unsigned j = 0; j < plen; j++)
          if (pat_mem[j] != wbps_pkg::Wildcard) region[at + j] = pat_mem[j];
      end
      for (int unsigned k = 0; k < rlen; k++) begin
        // noise: stray loads anywhere in the store, in the middle of a region
        if ($urandom_range(0, 11) == 0)
          send_req(mk_req(MODE_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        if ($urandom_range(0, 49) == 0) drain_pause();
        // mostly well-formed framing, sometimes a missing or a stray marker
        fb = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0);
        lb = (k == rlen - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 99) == 0);
        send_req(mk_req(MODE_SCAN, 8'($urandom_range(0, 255)), region[k], fb, lb));
      end
    end
  endtask

  // Receiver: random stalls of random length, none during calm stretches.
  always @(negedge clk_i) begin
    if (rx_hold != 0) rx_hold--;
    else if (!rx_calm && $urandom_range(0, 3) == 0) rx_hold = 1 + pick_gap(1'b0);
    m_axis_tready <= (rx_hold == 0);
  end

  // Every result taken from m_axis is matched against the oldest one owed.
  always @(posedge clk_i) begin : result_check
    scan_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.found = m_axis_tuser;
      got.addr  = m_axis_tdata[63:0];
      got.off   = m_axis_tdata[95:64];
      if (got.found) n_hits++;
      else n_misses++;
      if (res_q.size() == 0) begin
        $error("unexpected result: found=%0d match_address=%h match_offset=%0d",
               got.found, got.addr, got.off);
        n_err++;
      end else begin
        want = res_q.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          n_err++;
        end
        if (got.addr !== want.addr) begin
          $error("match_address: expected %h, got %h", want.addr, got.addr);
          n_err++;
        end
        if (got.off !== want.off) begin
          $error("match_offset: expected %0d, got %0d", want.off, got.off);
          n_err++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_LOAD;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = wbps_pkg::REG_PATTERN_LENGTH;
    cfg_data      = '0;
    seen_cnt      = '0;
    region_closed = 1'b0;
    cur_len       = 0;
    cur_base      = '0;
    rx_hold       = 0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    for (int i = 0; i < 256; i++) begin
      pat_mem[i]     = '0;
      pat_written[i] = 1'b0;
    end
    repeat (WinKeep) hist_q.push_back(8'h00);

    // Directed table. Out of reset: length 0, base 0.
    // Bytes with no region start count from offset zero; the last one closes it.
    dir_rows.push_back(scan_row(8'h00, 1'b0, 1'b0, CHK_NONE));
    dir_rows.push_back(scan_row(8'hFF, 1'b0, 1'b1, CHK_TYPED, NotFound));
    // region already answered: a second last byte gives nothing
    dir_rows.push_back(scan_row(8'h12, 1'b0, 1'b1, CHK_NONE));
    // first and last on one byte is a one-byte region
    dir_rows.push_back(scan_row(8'hA5, 1'b1, 1'b1, CHK_TYPED, NotFound));
    // pattern 00, wildcard, A5; top store entry loaded but never in use
    dir_rows.push_back(load_row(8'h00, 8'h00));
    dir_rows.push_back(load_row(8'h01, wbps_pkg::Wildcard));
    dir_rows.push_back(load_row(8'h02, 8'hA5));
    dir_rows.push_back(load_row(8'hFF, 8'h3C));
    dir_rows.push_back(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FF03));
    // zero base: a perfect match still reports not found
    dir_rows.push_back(scan_row(8'h00, 1'b1, 1'b0, CHK_NONE));
    dir_rows.push_back(scan_row(8'h11, 1'b0, 1'b0, CHK_MODEL));
    dir_rows.push_back(scan_row(8'hA5, 1'b0, 1'b1, CHK_TYPED, NotFound));
    dir_rows.push_back(reg_row(wbps_pkg::REG_REGION_BASE, 64'hFFFF_FFFF_FFFF_FFFF));
    // match completing on the final byte
    dir_rows.push_back(scan_row(8'h00, 1'b1, 1'b0, CHK_NONE));
    dir_rows.push_back(scan_row(8'h77, 1'b0, 1'b0, CHK_MODEL));
    dir_rows.push_back(scan_row(8'hA5, 1'b0, 1'b1, CHK_TYPED,
                                hit(64'hFFFF_FFFF_FFFF_FFFF, 32'd0)));
    // match at offset 2, address wraps past 2^64; trailing last byte ignored
    dir_rows.push_back(scan_row(8'h42, 1'b1, 1'b0, CHK_NONE));
    dir_rows.push_back(scan_row(8'h00, 1'b0, 1'b0, CHK_MODEL));
    dir_rows.push_back(scan_row(8'h00, 1'b0, 1'b0, CHK_MODEL));
    dir_rows.push_back(scan_row(8'hFF, 1'b0, 1'b0, CHK_MODEL));
    dir_rows.push_back(scan_row(8'hA5, 1'b0, 1'b0, CHK_TYPED, hit(64'd1, 32'd2)));
    dir_rows.push_back(scan_row(8'h10, 1'b0, 1'b1, CHK_NONE));
    // one-byte pattern in a one-byte region
    dir_rows.push_back(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'd1));
    dir_rows.push_back(reg_row(wbps_pkg::REG_REGION_BASE, 64'd1));
    dir_rows.push_back(scan_row(8'h00, 1'b1, 1'b1, CHK_TYPED, hit(64'd1, 32'd0)));
    // zero length never matches
    dir_rows.push_back(reg_row(wbps_pkg::REG_PATTERN_LENGTH, 64'd0));
    dir_rows.push_back(scan_row(8'h00, 1'b1, 1'b1, CHK_TYPED, NotFound));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      else send_req(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].want);
    end

    // Random phases with short patterns, then one with the longest pattern.
    while (n_req < dir_rows.size() + SmallPhaseItems)
      run_phase(pick_len(), pick_base(), $urandom_range(2, 6), 1, 12);
    run_phase(255, {$urandom, $urandom} | 64'd1, 1, 255, 16);

    drain_pause();
    repeat (2 * cur_len + 100) @(negedge clk_i);

    $display("Ran %0d requests (%0d pattern loads) over %0d register settings.",
             n_req, n_loads, n_settings);
    $display("Checked %0d results: %0d matches, %0d regions without one.",
             n_hits + n_misses, n_hits, n_misses);
    if (n_err == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
